[rtl/ripemd160_hash_unit_defines.svh]
// ----------------------------------------------------------------------------
// RIPEMD-160 hash unit assertion macros
// Shared property macros for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RIPEMD160_HASH_UNIT_DEFINES_SVH
`define RIPEMD160_HASH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define RMD_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define RMD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rmd160_pkg.sv]
// ----------------------------------------------------------------------------
// RIPEMD-160 package
// Word and line types, round control, schedule tables and constants.
// ----------------------------------------------------------------------------
package rmd160_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] line_t;
  typedef logic [6:0] rnd_t;

  typedef enum logic [2:0] {
    FN_XOR,
    FN_CHOOSE,
    FN_ORNOT,
    FN_SELECT,
    FN_XORNOT
  } fn_e;

  typedef struct packed {
    fn_e        fn;
    word_t      k;
    logic [3:0] amt;
  } round_ctl_t;

  localparam int unsigned Rounds = 80;
  localparam rnd_t LastRound = rnd_t'(Rounds - 1);

  localparam logic [3:0] WL_IDX [Rounds] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
    4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
    4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
    4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
    4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
    4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
    4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13
  };

  localparam logic [3:0] WR_IDX [Rounds] = '{
    4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
    4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
    4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
    4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
    4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
    4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
    4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
    4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
    4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
    4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11
  };

  localparam logic [3:0] SL_AMT [Rounds] = '{
    4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
    4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
    4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
    4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
    4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
    4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
    4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
    4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
    4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
    4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6
  };

  localparam logic [3:0] SR_AMT [Rounds] = '{
    4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
    4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
    4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
    4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
    4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
    4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
    4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
    4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
    4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
    4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11
  };

  localparam word_t KL [5] = '{
    32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E
  };

  localparam word_t KR [5] = '{
    32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000
  };

  localparam line_t INIT_CHAIN = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

endpackage

[rtl/rmd160_in_if.sv]
// ----------------------------------------------------------------------------
// RIPEMD-160 message channel
// Valid/ready channel that carries one message byte or end marker per transfer.
// ----------------------------------------------------------------------------
interface rmd160_in_if;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (
    output valid, data_byte, byte_present, end_of_message,
    input  ready
  );

  modport sink (
    input  valid, data_byte, byte_present, end_of_message,
    output ready
  );

endinterface

[rtl/rmd160_out_if.sv]
// ----------------------------------------------------------------------------
// RIPEMD-160 digest channel
// Valid/ready channel that carries one digest word per transfer.
// ----------------------------------------------------------------------------
interface rmd160_out_if;

  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (
    output valid, digest_word, word_index, last_word,
    input  ready
  );

  modport sink (
    input  valid, digest_word, word_index, last_word,
    output ready
  );

endinterface

[rtl/rmd160_round.sv]
// ----------------------------------------------------------------------------
// RIPEMD-160 round lane
// One step of a compression line: boolean function, add, rotate, shift.
// ----------------------------------------------------------------------------
module rmd160_round (
  input  rmd160_pkg::line_t      regs_i,
  input  rmd160_pkg::word_t      word_i,
  input  rmd160_pkg::round_ctl_t ctl_i,
  output rmd160_pkg::line_t      regs_o
);
  import rmd160_pkg::*;

  word_t       x;
  word_t       y;
  word_t       z;
  word_t       f;
  word_t       sum;
  logic [63:0] dbl;

  assign x = regs_i[1];
  assign y = regs_i[2];
  assign z = regs_i[3];

  always_comb begin
    unique case (ctl_i.fn)
      FN_XOR:    f = x ^ y ^ z;
      FN_CHOOSE: f = (x & y) | (~x & z);
      FN_ORNOT:  f = (x | ~y) ^ z;
      FN_SELECT: f = (x & z) | (y & ~z);
      FN_XORNOT: f = x ^ (y | ~z);
      default:   f = x ^ y ^ z;
    endcase
  end

  assign sum = regs_i[0] + f + word_i + ctl_i.k;
  assign dbl = {sum, sum} << ctl_i.amt;

  assign regs_o[1] = dbl[63:32] + regs_i[4];
  assign regs_o[0] = regs_i[4];
  assign regs_o[4] = regs_i[3];
  assign regs_o[3] = {regs_i[2][21:0], regs_i[2][31:22]};
  assign regs_o[2] = regs_i[1];

endmodule

[rtl/rmd160_block_mem.sv]
// ----------------------------------------------------------------------------
// RIPEMD-160 block memory
// Sixteen-word message block with one write port and two scheduled reads.
// ----------------------------------------------------------------------------
module rmd160_block_mem (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [3:0]        wr_addr_i,
  input  rmd160_pkg::word_t wr_data_i,
  input  rmd160_pkg::rnd_t  rnd_i,
  output rmd160_pkg::word_t rd_left_o,
  output rmd160_pkg::word_t rd_right_o
);
  import rmd160_pkg::*;

  word_t      mem_q [16];
  word_t      rd_left_q;
  word_t      rd_right_q;
  logic [3:0] addr_l;
  logic [3:0] addr_r;

  assign addr_l = WL_IDX[rnd_i];
  assign addr_r = WR_IDX[rnd_i];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_left_q  <= mem_q[addr_l];
    rd_right_q <= mem_q[addr_r];
  end

  assign rd_left_o  = rd_left_q;
  assign rd_right_o = rd_right_q;

endmodule

[rtl/ripemd160_hash_unit.sv]
// ----------------------------------------------------------------------------
// RIPEMD-160 hash unit
// Byte-serial RIPEMD-160 digest engine with one round datapath per lane, reused for every round.
// ----------------------------------------------------------------------------
// Message items arrive on msg_i, one byte per transfer, with byte_present
// and end_of_message flags. An item that ends the message may carry no byte.
// Bytes are taken back to back while the unit is idle. When a byte fills
// the 64-byte block, the unit runs a compression: a load step, 80 rounds
// with the left and right lanes working side by side, and a fold of the
// lines into the chaining words. ready stays low meanwhile.
// At the end of a message the padding words are written one per cycle and
// one more step closes the zero fill; a compression follows. If the length
// does not fit in the current block, the marker and zero fill end that
// block, a compression follows, and a second block of zeros and length
// words comes before the last one.
// The five digest words then appear on dig_o, h0 first, with last_word set
// on h4. A stalled receiver holds the unit in that state with the word
// stable. After h4 is transferred, the chaining words and byte count return
// to their initial values and msg_i is ready again. Reset is asynchronous.
// ----------------------------------------------------------------------------
`include "ripemd160_hash_unit_defines.svh"

module ripemd160_hash_unit (
  input logic           clk_i,
  input logic           rst_ni,
  rmd160_in_if.sink     msg_i,
  rmd160_out_if.source  dig_o
);
  import rmd160_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_e;

  localparam logic [4:0] LenWordLo = 5'd14;
  localparam logic [4:0] BlockWords = 5'd16;
  localparam logic [3:0] LenAddrLo = 4'd14;
  localparam logic [3:0] LenAddrHi = 4'd15;
  localparam logic [5:0] LastPos = 6'd63;
  localparam logic [2:0] LastWord = 3'd4;

  state_e      state_q, state_d;
  logic [63:0] count_q, count_d;
  word_t       acc_q, acc_d;
  logic [4:0]  wp_q, wp_d;
  logic        extra_q, extra_d;
  logic        finish_q, finish_d;
  logic        eom_pend_q, eom_pend_d;
  rnd_t        rnd_q, rnd_d;
  logic [2:0]  emit_q, emit_d;
  line_t       chain_q, chain_d;
  line_t       left_q, left_d;
  line_t       right_q, right_d;

  logic        mem_we;
  logic [3:0]  mem_wa;
  word_t       mem_wd;
  word_t       word_l;
  word_t       word_r;
  round_ctl_t  ctl_l;
  round_ctl_t  ctl_r;
  line_t       left_nxt;
  line_t       right_nxt;

  logic [5:0]  pos;
  logic [4:0]  lane_sh;
  word_t       byte_word;
  word_t       mark_word;
  logic [63:0] bit_len;

  assign pos       = count_q[5:0];
  assign lane_sh   = {pos[1:0], 3'b000};
  assign byte_word = ((pos[1:0] == 2'd0) ? '0 : acc_q)
                   | ({24'd0, msg_i.data_byte} << lane_sh);
  assign mark_word = ((pos[1:0] == 2'd0) ? '0 : acc_q) | (32'h0000_0080 << lane_sh);
  assign bit_len   = {count_q[60:0], 3'b000};

  assign ctl_l.fn  = fn_e'(rnd_q[6:4]);
  assign ctl_l.k   = KL[rnd_q[6:4]];
  assign ctl_l.amt = SL_AMT[rnd_q];
  assign ctl_r.fn  = fn_e'(3'd4 - rnd_q[6:4]);
  assign ctl_r.k   = KR[rnd_q[6:4]];
  assign ctl_r.amt = SR_AMT[rnd_q];

  rmd160_block_mem u_mem (
    .clk_i      (clk_i),
    .wr_en_i    (mem_we),
    .wr_addr_i  (mem_wa),
    .wr_data_i  (mem_wd),
    .rnd_i      (rnd_d),
    .rd_left_o  (word_l),
    .rd_right_o (word_r)
  );

  rmd160_round u_left (
    .regs_i (left_q),
    .word_i (word_l),
    .ctl_i  (ctl_l),
    .regs_o (left_nxt)
  );

  rmd160_round u_right (
    .regs_i (right_q),
    .word_i (word_r),
    .ctl_i  (ctl_r),
    .regs_o (right_nxt)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    acc_d      = acc_q;
    wp_d       = wp_q;
    extra_d    = extra_q;
    finish_d   = finish_q;
    eom_pend_d = eom_pend_q;
    rnd_d      = rnd_q;
    emit_d     = emit_q;
    chain_d    = chain_q;
    left_d     = left_q;
    right_d    = right_q;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (msg_i.valid) begin
          if (msg_i.byte_present) begin
            acc_d   = byte_word;
            mem_we  = 1'b1;
            mem_wa  = pos[5:2];
            mem_wd  = byte_word;
            count_d = count_q + 64'd1;
            if (pos == LastPos) begin
              eom_pend_d = msg_i.end_of_message;
              state_d    = ST_LOAD;
            end else if (msg_i.end_of_message) begin
              state_d = ST_MARK;
            end
          end else if (msg_i.end_of_message) begin
            state_d = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        mem_we  = 1'b1;
        mem_wa  = pos[5:2];
        mem_wd  = mark_word;
        wp_d    = {1'b0, pos[5:2]} + 5'd1;
        extra_d = (pos[5:3] == 3'b111);
        state_d = ST_ZERO;
      end
      ST_ZERO: begin
        if (wp_q < (extra_q ? BlockWords : LenWordLo)) begin
          mem_we = 1'b1;
          mem_wa = wp_q[3:0];
          wp_d   = wp_q + 5'd1;
        end else if (extra_q) begin
          state_d = ST_LOAD;
        end else begin
          state_d = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        mem_we  = 1'b1;
        mem_wa  = LenAddrLo;
        mem_wd  = bit_len[31:0];
        state_d = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        mem_we   = 1'b1;
        mem_wa   = LenAddrHi;
        mem_wd   = bit_len[63:32];
        finish_d = 1'b1;
        state_d  = ST_LOAD;
      end
      ST_LOAD: begin
        left_d  = chain_q;
        right_d = chain_q;
        rnd_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        left_d  = left_nxt;
        right_d = right_nxt;
        if (rnd_q == LastRound) begin
          rnd_d   = '0;
          state_d = ST_FOLD;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      ST_FOLD: begin
        chain_d[0] = chain_q[1] + left_q[2] + right_q[3];
        chain_d[1] = chain_q[2] + left_q[3] + right_q[4];
        chain_d[2] = chain_q[3] + left_q[4] + right_q[0];
        chain_d[3] = chain_q[4] + left_q[0] + right_q[1];
        chain_d[4] = chain_q[0] + left_q[1] + right_q[2];
        priority if (finish_q) begin
          finish_d = 1'b0;
          emit_d   = '0;
          state_d  = ST_EMIT;
        end else if (extra_q) begin
          extra_d = 1'b0;
          wp_d    = '0;
          state_d = ST_ZERO;
        end else if (eom_pend_q) begin
          eom_pend_d = 1'b0;
          state_d    = ST_MARK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (dig_o.ready) begin
          if (emit_q == LastWord) begin
            emit_d  = '0;
            chain_d = INIT_CHAIN;
            count_d = '0;
            state_d = ST_IDLE;
          end else begin
            emit_d = emit_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      acc_q      <= '0;
      wp_q       <= '0;
      extra_q    <= 1'b0;
      finish_q   <= 1'b0;
      eom_pend_q <= 1'b0;
      rnd_q      <= '0;
      emit_q     <= '0;
      chain_q    <= INIT_CHAIN;
      left_q     <= '0;
      right_q    <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      acc_q      <= acc_d;
      wp_q       <= wp_d;
      extra_q    <= extra_d;
      finish_q   <= finish_d;
      eom_pend_q <= eom_pend_d;
      rnd_q      <= rnd_d;
      emit_q     <= emit_d;
      chain_q    <= chain_d;
      left_q     <= left_d;
      right_q    <= right_d;
    end
  end

  assign msg_i.ready       = (state_q == ST_IDLE);
  assign dig_o.valid       = (state_q == ST_EMIT);
  assign dig_o.digest_word = chain_q[emit_q];
  assign dig_o.word_index  = emit_q;
  assign dig_o.last_word   = (emit_q == LastWord);

  `RMD_ASSERT_IMPLIES(a_no_overlap, msg_i.ready, !dig_o.valid, "Input ready while digest pending")
  `RMD_ASSERT_NEXT(a_restart, dig_o.valid && dig_o.ready && dig_o.last_word, msg_i.ready && (count_q == '0) && (chain_q == INIT_CHAIN), "State not restored after digest")
  `RMD_ASSERT_IMPLIES(a_fold_order, state_q == ST_FOLD, $past(state_q) == ST_ROUND && $past(rnd_q) == LastRound, "Fold without a full set of rounds")

endmodule
